// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands used by the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define CCSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Signal held stable while a valid item is stalled.
`define CCSD_HOLD(lbl, vld, rdy, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) \
    ((vld) && !(rdy)) |=> $stable(sig)) else $error(msg);

`endif

// ===== src/ccsd_pkg.sv =====
// ---------------------------------------------------------------------------
// ccsd_pkg
// Shared types and constants of the ChaCha20 stream decryptor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ccsd_pkg;

  localparam int unsigned TAG_BYTES = 16;

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  localparam logic [31:0] BLOCK_COUNT_START = 32'd1;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  localparam logic [1:0] OP_START_OK  = 2'd0;
  localparam logic [1:0] OP_START_REJ = 2'd1;
  localparam logic [1:0] OP_DATA      = 2'd2;

  localparam logic [1:0] STATUS_PLAIN     = 2'd0;
  localparam logic [1:0] STATUS_START_OK  = 2'd1;
  localparam logic [1:0] STATUS_START_REJ = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] cipher_byte;
    logic [5:0] offset;
    logic       last;
    logic       new_block;
  } op_t;

  typedef struct packed {
    logic [63:0] key_word0;
    logic [63:0] key_word1;
    logic [63:0] key_word2;
    logic [63:0] key_word3;
    logic [63:0] nonce_low;
    logic [31:0] nonce_high;
  } key_cfg_t;

endpackage

// ===== src/ccsd_stream_if.sv =====
// ---------------------------------------------------------------------------
// ccsd_stream_if
// Valid/ready channels for ciphertext commands and decrypted results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ccsd_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] cipher_byte;

  modport source (output valid, output cmd, output cipher_byte, input ready);
  modport sink   (input valid, input cmd, input cipher_byte, output ready);
endinterface

interface ccsd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] plain_byte;
  logic [1:0] status;
  logic       last;

  modport source (output valid, output plain_byte, output status, output last,
                  input ready);
  modport sink   (input valid, input plain_byte, input status, input last,
                  output ready);
endinterface

// ===== src/chacha20_stream_decrypt.sv =====
// ---------------------------------------------------------------------------
// chacha20_stream_decrypt
// ChaCha20 stream decryptor with APB register file, front end and back end.
// Path: start results and in-block bytes pass the queue and output register;
// the first byte of each 64-byte block waits for its 80 quarter rounds.
// Throughput: 1 item per cycle at the input while the queue has room; the
// back end takes no new item while the quarter-round unit computes a block.
// Reset: synchronous; clears registers, queue, message state, counter to one.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module chacha20_stream_decrypt (
  input  logic        clk,
  input  logic        rst,
  ccsd_in_if.sink     ingress,
  ccsd_out_if.source  egress,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import ccsd_pkg::*;

  localparam logic [2:0] REG_KEY0    = 3'd0;
  localparam logic [2:0] REG_KEY1    = 3'd1;
  localparam logic [2:0] REG_KEY2    = 3'd2;
  localparam logic [2:0] REG_KEY3    = 3'd3;
  localparam logic [2:0] REG_NONCE_L = 3'd4;
  localparam logic [2:0] REG_NONCE_H = 3'd5;
  localparam logic [2:0] REG_MSG_LEN = 3'd6;

  key_cfg_t    key_cfg;
  logic [31:0] message_length;
  logic [2:0]  reg_idx;
  logic        wr_en;

  op_t         push_op;
  op_t         head_op;
  logic        push;
  logic        pop;
  logic        q_full;
  logic        q_empty;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_cfg        <= '0;
      message_length <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_KEY0:    key_cfg.key_word0  <= pwdata;
        REG_KEY1:    key_cfg.key_word1  <= pwdata;
        REG_KEY2:    key_cfg.key_word2  <= pwdata;
        REG_KEY3:    key_cfg.key_word3  <= pwdata;
        REG_NONCE_L: key_cfg.nonce_low  <= pwdata;
        REG_NONCE_H: key_cfg.nonce_high <= pwdata[31:0];
        REG_MSG_LEN: message_length     <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_KEY0:    prdata = key_cfg.key_word0;
      REG_KEY1:    prdata = key_cfg.key_word1;
      REG_KEY2:    prdata = key_cfg.key_word2;
      REG_KEY3:    prdata = key_cfg.key_word3;
      REG_NONCE_L: prdata = key_cfg.nonce_low;
      REG_NONCE_H: prdata = {32'd0, key_cfg.nonce_high};
      REG_MSG_LEN: prdata = {32'd0, message_length};
      default:     prdata = 64'd0;
    endcase
  end

  ccsd_front u_front (
    .clk            (clk),
    .rst            (rst),
    .ingress        (ingress),
    .message_length (message_length),
    .queue_full     (q_full),
    .push           (push),
    .push_op        (push_op)
  );

  ccsd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push_op (push_op),
    .push    (push),
    .pop     (pop),
    .full    (q_full),
    .empty   (q_empty),
    .head_op (head_op)
  );

  ccsd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .key_cfg     (key_cfg),
    .head_op     (head_op),
    .queue_empty (q_empty),
    .pop         (pop),
    .egress      (egress)
  );

endmodule

// ===== src/ccsd_front.sv =====
// ---------------------------------------------------------------------------
// ccsd_front
// Accepts commands, tracks message position and queues work for the back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ccsd_front (
  input  logic            clk,
  input  logic            rst,
  ccsd_in_if.sink         ingress,
  input  logic [31:0]     message_length,
  input  logic            queue_full,
  output logic            push,
  output ccsd_pkg::op_t   push_op
);
  import ccsd_pkg::*;

  logic [31:0] byte_position;
  logic [31:0] plain_length;
  logic        message_active;

  logic        accept;
  logic [31:0] pos_inc;
  logic        at_end;
  logic        in_plain;

  assign ingress.ready = !queue_full;
  assign accept        = ingress.valid && !queue_full;

  assign pos_inc  = byte_position + 32'd1;
  assign at_end   = ({1'b0, byte_position} + 33'd1) >= ({1'b0, plain_length} + 33'(TAG_BYTES));
  assign in_plain = byte_position < plain_length;

  always_comb begin
    push                = 1'b0;
    push_op.kind        = OP_DATA;
    push_op.cipher_byte = ingress.cipher_byte;
    push_op.offset      = byte_position[5:0];
    push_op.last        = (pos_inc == plain_length);
    push_op.new_block   = (byte_position[5:0] == 6'd0);
    if (accept) begin
      if (!ingress.cmd) begin
        push = 1'b1;
        push_op.kind = (message_length < 32'(TAG_BYTES)) ? OP_START_REJ : OP_START_OK;
      end else if (message_active && in_plain) begin
        push = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      plain_length   <= '0;
      message_active <= 1'b0;
    end else if (accept) begin
      if (!ingress.cmd) begin
        if (message_length < 32'(TAG_BYTES)) begin
          message_active <= 1'b0;
        end else begin
          plain_length   <= message_length - 32'(TAG_BYTES);
          byte_position  <= '0;
          message_active <= (message_length != 32'd0);
        end
      end else if (message_active) begin
        byte_position <= pos_inc;
        if (at_end) begin
          message_active <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== src/ccsd_queue.sv =====
// ---------------------------------------------------------------------------
// ccsd_queue
// Short FIFO of classified work between the front and back ends.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ccsd_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  ccsd_pkg::op_t        push_op,
  input  logic                 push,
  input  logic                 pop,
  output logic                 full,
  output logic                 empty,
  output ccsd_pkg::op_t        head_op
);
  import ccsd_pkg::*;

  op_t            entries [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;
  logic           do_push;
  logic           do_pop;

  assign full    = (count == (QAW+1)'(QDEPTH));
  assign empty   = (count == '0);
  assign head_op = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + (QAW+1)'(1);
        2'b01:   count <= count - (QAW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/ccsd_back.sv =====
// ---------------------------------------------------------------------------
// ccsd_back
// Keystream generator on a shared quarter-round unit and output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ccsd_back (
  input  logic               clk,
  input  logic               rst,
  input  ccsd_pkg::key_cfg_t key_cfg,
  input  ccsd_pkg::op_t      head_op,
  input  logic               queue_empty,
  output logic               pop,
  ccsd_out_if.source         egress
);
  import ccsd_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ROUND = 2'd1;
  localparam logic [1:0] ST_FINAL = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  localparam int unsigned ROUND_STEPS = 80;
  localparam logic [6:0]  LAST_STEP   = 7'(ROUND_STEPS - 1);

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [127:0] quarter(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
    logic [31:0] ta, tb, tc, td;
    ta = a + b;   td = rotl(d ^ ta, 16);
    tc = c + td;  tb = rotl(b ^ tc, 12);
    ta = ta + tb; td = rotl(td ^ ta, 8);
    tc = tc + td; tb = rotl(tb ^ tc, 7);
    return {ta, tb, tc, td};
  endfunction

  // Row shift after a step: steady one word, and the turns into and out of
  // the diagonal layout.
  function automatic logic [1:0] rot_amt(input logic [2:0] s, input logic [1:0] r);
    case (s)
      3'd3:    return r + 2'd1;
      3'd7:    return r ^ 2'd1;
      default: return 2'd1;
    endcase
  endfunction

  logic [1:0]  state;
  logic [6:0]  step;
  logic [31:0] block_count;
  op_t         cur_op;
  logic [31:0] work [16];
  logic [31:0] ks [16];
  logic [31:0] init_w [16];
  logic [31:0] w_next [16];
  logic [31:0] row_new [4][4];
  logic [127:0] qr_out;

  logic        out_free;
  logic        emit;
  logic [1:0]  emit_status;
  logic [7:0]  emit_byte;
  logic        emit_last;
  logic        load_block;
  logic        reset_count;
  logic [5:0]  sel_off;
  logic [31:0] ks_word;
  logic [7:0]  ks_byte;

  logic        o_valid;
  logic [7:0]  o_plain;
  logic [1:0]  o_status;
  logic        o_last;

  assign egress.valid      = o_valid;
  assign egress.plain_byte = o_plain;
  assign egress.status     = o_status;
  assign egress.last       = o_last;
  assign out_free          = !o_valid || egress.ready;

  always_comb begin
    init_w[0]  = SIGMA0;
    init_w[1]  = SIGMA1;
    init_w[2]  = SIGMA2;
    init_w[3]  = SIGMA3;
    init_w[4]  = key_cfg.key_word0[31:0];
    init_w[5]  = key_cfg.key_word0[63:32];
    init_w[6]  = key_cfg.key_word1[31:0];
    init_w[7]  = key_cfg.key_word1[63:32];
    init_w[8]  = key_cfg.key_word2[31:0];
    init_w[9]  = key_cfg.key_word2[63:32];
    init_w[10] = key_cfg.key_word3[31:0];
    init_w[11] = key_cfg.key_word3[63:32];
    init_w[12] = block_count;
    init_w[13] = key_cfg.nonce_low[31:0];
    init_w[14] = key_cfg.nonce_low[63:32];
    init_w[15] = key_cfg.nonce_high;
  end

  assign qr_out = quarter(work[0], work[4], work[8], work[12]);

  always_comb begin
    logic [1:0] idx;
    idx = 2'd0;
    for (int r = 0; r < 4; r++) begin
      row_new[r][0] = qr_out[127 - 32*r -: 32];
      for (int j = 1; j < 4; j++) begin
        row_new[r][j] = work[4*r + j];
      end
    end
    for (int r = 0; r < 4; r++) begin
      for (int j = 0; j < 4; j++) begin
        idx = 2'(j) + rot_amt(step[2:0], 2'(r));
        w_next[4*r + j] = row_new[r][idx];
      end
    end
  end

  assign sel_off = (state == ST_EMIT) ? cur_op.offset : head_op.offset;
  assign ks_word = ks[sel_off[5:2]];
  assign ks_byte = 8'(ks_word >> {sel_off[1:0], 3'b000});

  always_comb begin
    pop         = 1'b0;
    emit        = 1'b0;
    emit_status = STATUS_PLAIN;
    emit_byte   = 8'd0;
    emit_last   = 1'b0;
    load_block  = 1'b0;
    reset_count = 1'b0;
    case (state)
      ST_IDLE: begin
        if (!queue_empty) begin
          case (head_op.kind)
            OP_START_OK: begin
              if (out_free) begin
                pop         = 1'b1;
                emit        = 1'b1;
                emit_status = STATUS_START_OK;
                reset_count = 1'b1;
              end
            end
            OP_START_REJ: begin
              if (out_free) begin
                pop         = 1'b1;
                emit        = 1'b1;
                emit_status = STATUS_START_REJ;
              end
            end
            OP_DATA: begin
              if (head_op.new_block) begin
                pop        = 1'b1;
                load_block = 1'b1;
              end else if (out_free) begin
                pop       = 1'b1;
                emit      = 1'b1;
                emit_byte = head_op.cipher_byte ^ ks_byte;
                emit_last = head_op.last;
              end
            end
            default: pop = 1'b1;
          endcase
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_byte = cur_op.cipher_byte ^ ks_byte;
          emit_last = cur_op.last;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_block) begin
      cur_op <= head_op;
      for (int i = 0; i < 16; i++) begin
        work[i] <= init_w[i];
      end
    end else if (state == ST_ROUND) begin
      for (int i = 0; i < 16; i++) begin
        work[i] <= w_next[i];
      end
    end
    if (state == ST_FINAL) begin
      for (int i = 0; i < 16; i++) begin
        ks[i] <= work[i] + init_w[i];
      end
    end
    if (emit) begin
      o_plain  <= emit_byte;
      o_status <= emit_status;
      o_last   <= emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      step        <= '0;
      block_count <= BLOCK_COUNT_START;
      o_valid     <= 1'b0;
    end else begin
      if (emit) begin
        o_valid <= 1'b1;
      end else if (egress.ready) begin
        o_valid <= 1'b0;
      end
      if (reset_count) begin
        block_count <= BLOCK_COUNT_START;
      end
      case (state)
        ST_IDLE: begin
          if (load_block) begin
            step  <= '0;
            state <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          step <= step + 7'd1;
          if (step == LAST_STEP) begin
            state <= ST_FINAL;
          end
        end
        ST_FINAL: begin
          block_count <= block_count + 32'd1;
          state       <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== src/ccsd_checker.sv =====
// ---------------------------------------------------------------------------
// ccsd_checker
// Port-level checks on the result channel of the stream decryptor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ccsd_checker (
  input logic       clk,
  input logic       rst,
  input logic       o_valid,
  input logic       o_ready,
  input logic [7:0] o_plain,
  input logic [1:0] o_status,
  input logic       o_last
);
  import ccsd_pkg::*;

  `CCSD_HOLD(a_valid_hold, o_valid, o_ready, o_valid, "result dropped while stalled")
  `CCSD_HOLD(a_payload_hold, o_valid, o_ready, {o_plain, o_status, o_last}, "result changed while stalled")
  `CCSD_ASSERT(a_status_code, o_valid |-> (o_status == STATUS_PLAIN || o_status == STATUS_START_OK || o_status == STATUS_START_REJ), "bad status code")
  `CCSD_ASSERT(a_start_clean, (o_valid && o_status != STATUS_PLAIN) |-> (o_plain == 8'd0 && !o_last), "start result carries data")

endmodule

bind chacha20_stream_decrypt ccsd_checker u_ccsd_checker (
  .clk      (clk),
  .rst      (rst),
  .o_valid  (egress.valid),
  .o_ready  (egress.ready),
  .o_plain  (egress.plain_byte),
  .o_status (egress.status),
  .o_last   (egress.last)
);

// ===== tb/chacha20_stream_decrypt_tb.sv =====
// ---------------------------------------------------------------------------
// chacha20_stream_decrypt_tb
// Self-checking bench for the ChaCha20 stream decryptor. Writes key, nonce
// and message length over APB, drives start commands and ciphertext bytes
// under several idling patterns, predicts every result with its own
// ChaCha20 block function and compares each result field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module chacha20_stream_decrypt_tb;
  import ccsd_pkg::*;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_BYTE  = 1'b1;

  localparam logic [5:0] ADDR_KEY0     = 6'd0;
  localparam logic [5:0] ADDR_KEY1     = 6'd8;
  localparam logic [5:0] ADDR_KEY2     = 6'd16;
  localparam logic [5:0] ADDR_KEY3     = 6'd24;
  localparam logic [5:0] ADDR_NONCE_LO = 6'd32;
  localparam logic [5:0] ADDR_NONCE_HI = 6'd40;
  localparam logic [5:0] ADDR_MSG_LEN  = 6'd48;

  localparam logic [31:0] CHACHA_C0 = 32'h61707865;
  localparam logic [31:0] CHACHA_C1 = 32'h3320646e;
  localparam logic [31:0] CHACHA_C2 = 32'h79622d32;
  localparam logic [31:0] CHACHA_C3 = 32'h6b206574;
  localparam logic [31:0] TAG_LEN   = 32'd16;

  localparam int SEND_IDLE  [4] = '{0, 82, 0, 28};
  localparam int RECV_STALL [4] = '{0, 0, 82, 28};
  localparam int PHASE_ITEMS     = 60;
  localparam int SETTLE_CYCLES   = 200;
  localparam int PRESSURE_CYCLES = 300;
  localparam int TIMEOUT_NS      = 3_000_000;

  typedef struct packed {
    logic       cmd;
    logic [7:0] cipher_byte;
  } cipher_item_t;

  typedef struct packed {
    logic [7:0] plain_byte;
    logic [1:0] status;
    logic       last;
  } plain_result_t;

  typedef logic [15:0][31:0] chacha_words_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  ccsd_in_if  cipher_ch ();
  ccsd_out_if plain_ch ();

  chacha20_stream_decrypt DUT (
    .clk     (clk),
    .rst     (rst),
    .ingress (cipher_ch),
    .egress  (plain_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [63:0]   cfg_key [4];
  logic [63:0]   cfg_nonce_lo;
  logic [31:0]   cfg_nonce_hi;
  logic [31:0]   cfg_msg_len;

  chacha_words_t keystream;
  logic [31:0]   blk_count;
  logic [31:0]   byte_pos;
  logic [31:0]   plain_len;
  logic          msg_active;

  cipher_item_t  cipher_pending [$];
  plain_result_t plain_expect [$];

  int   n_errors = 0;
  int   n_accepted = 0;
  int   n_checked = 0;
  int   n_blocks = 0;
  int   n_rejects = 0;
  int   n_settings = 0;
  int   phase_load = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic hold_start = 1'b0;
  logic hold_active = 1'b0;
  int   hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("chacha20_stream_decrypt_tb: errors");
    $finish;
  end

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic void quarter_round(inout chacha_words_t w,
                                        input int a, input int b,
                                        input int c, input int d);
    w[a] = w[a] + w[b]; w[d] = rotl32(w[d] ^ w[a], 16);
    w[c] = w[c] + w[d]; w[b] = rotl32(w[b] ^ w[c], 12);
    w[a] = w[a] + w[b]; w[d] = rotl32(w[d] ^ w[a], 8);
    w[c] = w[c] + w[d]; w[b] = rotl32(w[b] ^ w[c], 7);
  endfunction

  function automatic chacha_words_t chacha_block(input logic [31:0] counter);
    chacha_words_t start_w;
    chacha_words_t w;
    start_w[0] = CHACHA_C0;
    start_w[1] = CHACHA_C1;
    start_w[2] = CHACHA_C2;
    start_w[3] = CHACHA_C3;
    for (int i = 0; i < 4; i++) begin
      start_w[4 + 2 * i] = cfg_key[i][31:0];
      start_w[5 + 2 * i] = cfg_key[i][63:32];
    end
    start_w[12] = counter;
    start_w[13] = cfg_nonce_lo[31:0];
    start_w[14] = cfg_nonce_lo[63:32];
    start_w[15] = cfg_nonce_hi;
    w = start_w;
    for (int r = 0; r < 10; r++) begin
      quarter_round(w, 0, 4, 8, 12);
      quarter_round(w, 1, 5, 9, 13);
      quarter_round(w, 2, 6, 10, 14);
      quarter_round(w, 3, 7, 11, 15);
      quarter_round(w, 0, 5, 10, 15);
      quarter_round(w, 1, 6, 11, 12);
      quarter_round(w, 2, 7, 8, 13);
      quarter_round(w, 3, 4, 9, 14);
    end
    for (int i = 0; i < 16; i++) w[i] = w[i] + start_w[i];
    return w;
  endfunction

  function automatic void predict_decrypt(input logic cmd, input logic [7:0] cbyte);
    plain_result_t r;
    logic [5:0]    off;
    logic [31:0]   ks_word;
    r = '0;
    if (cmd == CMD_START) begin
      if (cfg_msg_len < TAG_LEN) begin
        msg_active = 1'b0;
        r.status = STATUS_START_REJ;
        n_rejects++;
      end else begin
        plain_len = cfg_msg_len - TAG_LEN;
        byte_pos = '0;
        blk_count = 32'd1;
        msg_active = 1'b1;
        r.status = STATUS_START_OK;
      end
      plain_expect.push_back(r);
    end else if (msg_active) begin
      if (byte_pos < plain_len) begin
        off = byte_pos[5:0];
        if (off == 6'd0) begin
          keystream = chacha_block(blk_count);
          blk_count = blk_count + 32'd1;
          n_blocks++;
        end
        ks_word = keystream[off[5:2]];
        r.plain_byte = cbyte ^ ks_word[{off[1:0], 3'b000} +: 8];
        r.status = STATUS_PLAIN;
        r.last = (byte_pos + 32'd1 == plain_len);
        plain_expect.push_back(r);
      end
      byte_pos = byte_pos + 32'd1;
      if ({1'b0, byte_pos} >= {1'b0, plain_len} + {1'b0, TAG_LEN}) msg_active = 1'b0;
    end
  endfunction

  always @(posedge clk) begin : cipher_driver
    cipher_item_t nxt;
    if (rst) begin
      cipher_ch.valid <= 1'b0;
    end else if (!cipher_ch.valid || cipher_ch.ready) begin
      if (cipher_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = cipher_pending.pop_front();
        cipher_ch.valid <= 1'b1;
        cipher_ch.cmd <= nxt.cmd;
        cipher_ch.cipher_byte <= nxt.cipher_byte;
      end else begin
        cipher_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      hold_active <= 1'b0;
      hold_left <= 0;
    end else if (hold_start && !hold_active) begin
      hold_active <= 1'b1;
      hold_left <= PRESSURE_CYCLES;
    end else if (hold_active) begin
      hold_left <= hold_left - 1;
      if (hold_left == 1) hold_active <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      plain_ch.ready <= 1'b0;
    end else begin
      plain_ch.ready <= !hold_active && !hold_start &&
                        ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : result_monitor
    plain_result_t want;
    if (!rst) begin
      if (cipher_ch.valid && cipher_ch.ready) begin
        predict_decrypt(cipher_ch.cmd, cipher_ch.cipher_byte);
        n_accepted++;
      end
      if (plain_ch.valid && plain_ch.ready) begin
        n_checked++;
        if (plain_expect.size() == 0) begin
          n_errors++;
          $error("unexpected result: plain_byte %02h status %0d last %0b",
                 plain_ch.plain_byte, plain_ch.status, plain_ch.last);
        end else begin
          want = plain_expect.pop_front();
          if (plain_ch.plain_byte !== want.plain_byte) begin
            n_errors++;
            $error("plain_byte: expected %02h, got %02h", want.plain_byte,
                   plain_ch.plain_byte);
          end
          if (plain_ch.status !== want.status) begin
            n_errors++;
            $error("status: expected %0d, got %0d", want.status, plain_ch.status);
          end
          if (plain_ch.last !== want.last) begin
            n_errors++;
            $error("last: expected %0b, got %0b", want.last, plain_ch.last);
          end
        end
      end
    end
  end

  task automatic reg_write(input logic [5:0] addr, input logic [63:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (addr)
      ADDR_KEY0:     cfg_key[0] = data;
      ADDR_KEY1:     cfg_key[1] = data;
      ADDR_KEY2:     cfg_key[2] = data;
      ADDR_KEY3:     cfg_key[3] = data;
      ADDR_NONCE_LO: cfg_nonce_lo = data;
      ADDR_NONCE_HI: cfg_nonce_hi = data[31:0];
      ADDR_MSG_LEN:  cfg_msg_len = data[31:0];
      default: ;
    endcase
  endtask

  task automatic push_item(input logic cmd, input logic [7:0] b);
    cipher_item_t it;
    it.cmd = cmd;
    it.cipher_byte = b;
    cipher_pending.push_back(it);
  endtask

  task automatic push_bytes(input int n);
    for (int i = 0; i < n; i++) push_item(CMD_BYTE, 8'($urandom_range(255)));
  endtask

  task automatic wait_idle();
    while (cipher_pending.size() != 0 || cipher_ch.valid || plain_expect.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [63:0] pick_word(input int mode);
    case (mode)
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic load_round();
    int          mode;
    int          kind;
    int          n;
    int          target;
    int          round_items;
    logic [31:0] len;
    mode = (n_settings < 2) ? n_settings : $urandom_range(5);
    reg_write(ADDR_KEY0, pick_word(mode));
    reg_write(ADDR_KEY1, pick_word(mode));
    reg_write(ADDR_KEY2, pick_word(mode));
    reg_write(ADDR_KEY3, pick_word(mode));
    reg_write(ADDR_NONCE_LO, pick_word(mode));
    reg_write(ADDR_NONCE_HI, pick_word(mode));
    kind = $urandom_range(99);
    if (kind < 12) begin
      len = ($urandom_range(1) == 0) ? 32'd15 : 32'($urandom_range(15));
    end else if (kind < 24) begin
      len = ($urandom_range(1) == 0) ? 32'hFFFF_FFFF :
            32'($urandom_range(32'hFFFF_FFFE, 32'h0001_0000));
    end else begin
      case ($urandom_range(3))
        0: len = TAG_LEN;
        1: len = TAG_LEN + 32'(64 * $urandom_range(1, 2));
        default: len = TAG_LEN + 32'($urandom_range(140));
      endcase
    end
    reg_write(ADDR_MSG_LEN, {32'($urandom), len});
    n_settings++;
    @(negedge clk);
    // continue a message left open by the last round, or drop
    push_bytes($urandom_range(4));
    round_items = 0;
    target = (len < TAG_LEN) ? 6 : 40 + $urandom_range(30);
    while (round_items < target) begin
      push_item(CMD_START, 8'($urandom_range(255)));
      round_items++;
      if (len < TAG_LEN) begin
        push_bytes($urandom_range(3));
      end else begin
        if (len > 32'd1000)
          n = ($urandom_range(1) == 0) ? 64 * $urandom_range(1, 2) : $urandom_range(1, 150);
        else if ($urandom_range(99) < 75)
          n = int'(len);
        else
          n = $urandom_range(int'(len) - 1);
        push_bytes(n);
        round_items += n;
        if (n == int'(len)) push_bytes($urandom_range(2));
      end
    end
    phase_load += round_items;
  endtask

  initial begin : stimulus
    bit pressure_done;
    pressure_done = 1'b0;
    cipher_ch.valid = 1'b0;
    cipher_ch.cmd = CMD_START;
    cipher_ch.cipher_byte = '0;
    plain_ch.ready = 1'b0;
    for (int i = 0; i < 4; i++) cfg_key[i] = '0;
    cfg_nonce_lo = '0;
    cfg_nonce_hi = '0;
    cfg_msg_len = '0;
    keystream = '0;
    blk_count = 32'd1;
    byte_pos = '0;
    plain_len = '0;
    msg_active = 1'b0;
    rst = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    push_item(CMD_BYTE, 8'hA5);
    push_item(CMD_START, 8'h00);
    push_item(CMD_BYTE, 8'h5A);
    wait_idle();
    reg_write(ADDR_MSG_LEN, 64'd15);
    @(negedge clk);
    push_item(CMD_START, 8'hFF);
    push_item(CMD_BYTE, 8'h3C);
    wait_idle();
    reg_write(ADDR_MSG_LEN, 64'd18);
    @(negedge clk);
    push_item(CMD_START, 8'h00);
    push_item(CMD_BYTE, 8'h00);
    push_item(CMD_BYTE, 8'hFF);
    for (int i = 0; i < 16; i++) push_item(CMD_BYTE, (i % 2 == 0) ? 8'h00 : 8'hFF);
    push_item(CMD_BYTE, 8'h81);
    wait_idle();
    reg_write(ADDR_MSG_LEN, 64'hFFFF_FFFF);
    @(negedge clk);
    push_item(CMD_START, 8'h00);
    push_item(CMD_BYTE, 8'hFF);
    push_item(CMD_START, 8'hFF);
    push_item(CMD_BYTE, 8'h00);
    push_item(CMD_BYTE, 8'h01);
    wait_idle();

    for (int phase = 0; phase < 4; phase++) begin
      @(negedge clk);
      send_idle_pct = SEND_IDLE[phase];
      recv_stall_pct = RECV_STALL[phase];
      phase_load = 0;
      while (phase_load < PHASE_ITEMS) begin
        load_round();
        if (!pressure_done) begin
          // hold off the receiver so the block backs up into its input
          hold_start = 1'b1;
          @(negedge clk);
          hold_start = 1'b0;
          pressure_done = 1'b1;
        end
        wait_idle();
      end
    end

    $display("Run covered %0d accepted items and %0d checked results over %0d settings,",
             n_accepted, n_checked, n_settings);
    $display("with %0d keystream blocks generated and %0d rejected starts.",
             n_blocks, n_rejects);
    if (n_errors == 0) begin
      $display("chacha20_stream_decrypt_tb: clean");
    end else begin
      $display("chacha20_stream_decrypt_tb: errors");
    end
    $finish;
  end

endmodule
